@@ hw/rtl/rtc_pkg.sv @@
// Shared types and constants for the RGB to CMYK plane converter.
`default_nettype none

package rtc_pkg;

    // Pixel component width.
    localparam int PIX_W = 8;
    // Dividend width: 510 * 255 + 255 fits in 17 bits.
    localparam int NUM_W = 17;
    // Quotient bits resolved by each divider stage.
    localparam int BITS_PER_STEP = 2;
    // Number of divider stages for an 8-bit quotient.
    localparam int DIV_STAGES = PIX_W / BITS_PER_STEP;
    // Two front stages, the divider stages, one output register.
    localparam int NUM_STAGES = 2 + DIV_STAGES + 1;
    // Full-scale component value.
    localparam logic [PIX_W-1:0] PIX_FULL = 8'hFF;
    // Chromatic lanes: cyan, magenta, yellow.
    localparam int LANES = 3;

    // One lane of the restoring divider.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [PIX_W-1:0] quo;
    } t_div_lane;

    // One pixel traveling through the divider.
    typedef struct packed {
        t_div_lane [LANES-1:0] lane;
        logic [NUM_W-1:0]      dvsr;
        logic [PIX_W-1:0]      top;
        logic [PIX_W-1:0]      alpha;
    } t_div_item;

endpackage

`default_nettype wire

@@ hw/rtl/rgb_to_cmyk_planes_core.sv @@
// Top level of the RGB to CMYK plane converter: stage control and output register.
//
//  Port group   Dir  Payload (lowest bit first)
//  i_s_*        in   tdata[31:0]: red, green, blue, alpha
//  o_m_*        out  tdata[39:0]: cyan_plane, magenta_plane, yellow_plane,
//                                 black_plane, alpha_out
//
// Data passes through seven register stages: two front stages (maximum,
// dividends), four divider stages of two quotient bits each, and the output
// register. One pixel is taken per cycle while the input is not held off.
// Reset clears the stage valid bits only; data registers are not reset.
// A stall on the output fills empty stages before the input is held off.
`default_nettype none

module rgb_to_cmyk_planes_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // red, green, blue, alpha
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata    // cyan, magenta, yellow, black, alpha
);

    localparam int NS = rtc_pkg::NUM_STAGES;
    localparam int ND = rtc_pkg::DIV_STAGES;

    logic [NS-1:0]      r_vld;
    logic [NS-1:0]      n_vld;
    logic [NS-1:0]      adv;
    rtc_pkg::t_div_item div_item [ND+1];
    logic [39:0]        r_out;
    logic [39:0]        n_out;
    logic [7:0]         plane [rtc_pkg::LANES];

    // A stage loads when it is empty or its successor loads too.
    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || i_m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            adv[i] = !r_vld[i] || adv[i+1];
        end
    end

    // Valid bits travel with the data.
    always_comb begin
        n_vld = r_vld;
        for (int i = 0; i < NS; i++) begin
            if (adv[i]) begin
                n_vld[i] = (i == 0) ? i_s_tvalid : r_vld[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Maximum and divider operands.
    rtc_front u_front (
        .i_clk  (i_clk),
        .i_en   (adv[1:0]),
        .i_pix  (i_s_tdata),
        .o_item (div_item[0])
    );

    // Divider pipeline.
    for (genvar k = 0; k < ND; k++) begin : g_div
        rtc_div_step u_step (
            .i_clk  (i_clk),
            .i_en   (adv[2+k]),
            .i_item (div_item[k]),
            .o_item (div_item[k+1])
        );
    end

    // Inverted plane values; a black pixel carries no chromatic ink.
    always_comb begin
        for (int i = 0; i < rtc_pkg::LANES; i++) begin
            if (div_item[ND].top == '0) begin
                plane[i] = rtc_pkg::PIX_FULL;
            end else begin
                plane[i] = rtc_pkg::PIX_FULL - div_item[ND].lane[i].quo;
            end
        end
        n_out = {div_item[ND].alpha, div_item[ND].top, plane[2], plane[1], plane[0]};
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (adv[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_s_tready = adv[0];
    assign o_m_tvalid = r_vld[NS-1];
    assign o_m_tdata  = r_out;

    // An empty output register never holds off the input.
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output register empty");

    // A black pixel gives no chromatic ink.
    a_black_pixel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[31:24] == 8'h00) |->
        (o_m_tdata[7:0] == 8'hFF && o_m_tdata[15:8] == 8'hFF
         && o_m_tdata[23:16] == 8'hFF))
        else $error("black pixel produced chromatic ink");

    // The largest component always has zero ink.
    a_max_lane_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
        (o_m_tdata[7:0] == 8'hFF || o_m_tdata[15:8] == 8'hFF
         || o_m_tdata[23:16] == 8'hFF))
        else $error("no plane free of ink");

endmodule

`default_nettype wire

@@ hw/rtl/rtc_front.sv @@
// Front stages: maximum component search, then ink dividends and divisor.
`default_nettype none

module rtc_front (
    input  wire logic                  i_clk,
    input  wire logic [1:0]            i_en,     // Load enables for the two stages.
    input  wire logic [31:0]           i_pix,    // red, green, blue, alpha
    output rtc_pkg::t_div_item         o_item
);

    logic [rtc_pkg::PIX_W-1:0] r_comp [rtc_pkg::LANES];
    logic [rtc_pkg::PIX_W-1:0] r_alpha;
    logic [rtc_pkg::PIX_W-1:0] r_top;
    logic [rtc_pkg::PIX_W-1:0] n_top;
    rtc_pkg::t_div_item        r_item;
    rtc_pkg::t_div_item        n_item;
    logic [rtc_pkg::PIX_W-1:0] diff [rtc_pkg::LANES];

    // The largest of red, green and blue.
    always_comb begin
        n_top = i_pix[7:0];
        if (i_pix[15:8] > n_top) begin
            n_top = i_pix[15:8];
        end
        if (i_pix[23:16] > n_top) begin
            n_top = i_pix[23:16];
        end
    end

    // Stage one registers the components and their maximum.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_comp[0] <= i_pix[7:0];
            r_comp[1] <= i_pix[15:8];
            r_comp[2] <= i_pix[23:16];
            r_alpha   <= i_pix[31:24];
            r_top     <= n_top;
        end
    end

    // Dividend is 510 * (max - comp) + max; divisor 2 * max is aligned to
    // the top quotient bit, which places it at max shifted left by eight.
    always_comb begin
        n_item = '0;
        for (int i = 0; i < rtc_pkg::LANES; i++) begin
            diff[i] = r_top - r_comp[i];
            n_item.lane[i].rem = ({1'b0, diff[i], 8'b0} << 1)
                               - {8'b0, diff[i], 1'b0}
                               + {9'b0, r_top};
            n_item.lane[i].quo = '0;
        end
        n_item.dvsr  = {1'b0, r_top, 8'b0};
        n_item.top   = r_top;
        n_item.alpha = r_alpha;
    end

    // Stage two registers the divider operands.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

@@ hw/rtl/rtc_div_step.sv @@
// One restoring divider stage that resolves two quotient bits per lane.
`default_nettype none

module rtc_div_step (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire rtc_pkg::t_div_item i_item,
    output rtc_pkg::t_div_item      o_item
);

    rtc_pkg::t_div_item r_item;
    rtc_pkg::t_div_item n_item;

    // Each bit step subtracts the aligned divisor where it fits, then
    // moves the divisor one place down.
    always_comb begin
        n_item = i_item;
        for (int s = 0; s < rtc_pkg::BITS_PER_STEP; s++) begin
            for (int i = 0; i < rtc_pkg::LANES; i++) begin
                if (n_item.lane[i].rem >= n_item.dvsr) begin
                    n_item.lane[i].rem = n_item.lane[i].rem - n_item.dvsr;
                    n_item.lane[i].quo = {n_item.lane[i].quo[rtc_pkg::PIX_W-2:0], 1'b1};
                end else begin
                    n_item.lane[i].quo = {n_item.lane[i].quo[rtc_pkg::PIX_W-2:0], 1'b0};
                end
            end
            n_item.dvsr = n_item.dvsr >> 1;
        end
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire
